@@ design/dif3d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dif3d_pkg: shared types and constants of the 3D diffusion stencil core
// Grid geometry, address layout, command format and coordinate helpers.
// ----------------------------------------------------------------------------
package dif3d_pkg;

	// grid geometry
	localparam int SIZE_X = 16;
	localparam int SIZE_Y = 16;
	localparam int SIZE_Z = 16;

	localparam int POS_W  = 4;   // width of a coordinate on the input port
	localparam int CX_W   = $clog2(SIZE_X);
	localparam int CY_W   = $clog2(SIZE_Y);
	localparam int CZ_W   = $clog2(SIZE_Z);

	localparam int POINTS    = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int PT_W      = $clog2(POINTS);
	localparam int ADDR_W    = PT_W + 1;          // bank bit on top
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	// a 4-bit coordinate needs at most this many subtractions of the smallest axis
	localparam int WRAP_STEPS = 5;

	localparam int DATA_W = 32;
	localparam int GAIN_W = 16;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd655;

	// queues
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH = 8;
	localparam int OQ_PW      = $clog2(OUTQ_DEPTH);
	localparam int OQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

	// request codes on the input port
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_UPDATE = 2'd1;
	localparam logic [1:0] REQ_SWAP   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_GAIN_X = 2'd0;
	localparam logic [1:0] CFG_GAIN_Y = 2'd1;
	localparam logic [1:0] CFG_GAIN_Z = 2'd2;

	typedef logic [CX_W-1:0] cx_t;
	typedef logic [CY_W-1:0] cy_t;
	typedef logic [CZ_W-1:0] cz_t;
	typedef logic [PT_W-1:0] pt_t;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_UPDATE,
		KIND_SWAP
	} kind_t;

	// one classified request, coordinates already wrapped
	typedef struct packed {
		kind_t                    kind;
		cx_t                      x;
		cx_t                      xp;
		cx_t                      xm;
		cy_t                      y;
		cy_t                      yp;
		cy_t                      ym;
		cz_t                      z;
		cz_t                      zp;
		cz_t                      zm;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	// centre and its six neighbors
	typedef struct packed {
		logic signed [DATA_W-1:0] c;
		logic signed [DATA_W-1:0] xp;
		logic signed [DATA_W-1:0] xm;
		logic signed [DATA_W-1:0] yp;
		logic signed [DATA_W-1:0] ym;
		logic signed [DATA_W-1:0] zp;
		logic signed [DATA_W-1:0] zm;
	} stencil_t;

	// reduce a port coordinate below the axis size by repeated subtraction
	function automatic logic [7:0] wrap_coord(logic [POS_W-1:0] pos, logic [7:0] size);
		logic [7:0] r;
		r = {4'b0000, pos};
		for (int i = 0; i < WRAP_STEPS; i++) begin
			if (r >= size) begin
				r = r - size;
			end
		end
		return r;
	endfunction

	// point index within one bank: (x * SIZE_Y + y) * SIZE_Z + z
	function automatic pt_t point_index(cx_t x, cy_t y, cz_t z);
		pt_t r;
		r = (PT_W'(x) * PT_W'(SIZE_Y) + PT_W'(y)) * PT_W'(SIZE_Z) + PT_W'(z);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/dif3d_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dif3d_ram: generic RAM, one write port, two registered read ports
// ----------------------------------------------------------------------------
module dif3d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule
`default_nettype wire

@@ design/dif3d_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dif3d_front: request intake
// Decodes the request, wraps coordinates and neighbors, queues the command.
// ----------------------------------------------------------------------------
module dif3d_front import dif3d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic [POS_W-1:0]         x_pos,
	input  logic [POS_W-1:0]         y_pos,
	input  logic [POS_W-1:0]         z_pos,
	input  logic signed [DATA_W-1:0] sample_value,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  logic                     cmd_pop
);

	cx_t   x, xp, xm;
	cy_t   y, yp, ym;
	cz_t   z, zp, zm;
	kind_t kind;
	logic  push;
	cmd_t  entry;

	cmd_t                  cq_mem_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0]    cq_wr_q;
	logic [CMDQ_PW-1:0]    cq_rd_q;
	logic [CMDQ_CNT_W-1:0] cq_cnt_q;

	assign x = CX_W'(wrap_coord(x_pos, 8'(SIZE_X)));
	assign y = CY_W'(wrap_coord(y_pos, 8'(SIZE_Y)));
	assign z = CZ_W'(wrap_coord(z_pos, 8'(SIZE_Z)));

	assign xp = (x == CX_W'(SIZE_X - 1)) ? '0 : x + CX_W'(1);
	assign xm = (x == '0) ? CX_W'(SIZE_X - 1) : x - CX_W'(1);
	assign yp = (y == CY_W'(SIZE_Y - 1)) ? '0 : y + CY_W'(1);
	assign ym = (y == '0) ? CY_W'(SIZE_Y - 1) : y - CY_W'(1);
	assign zp = (z == CZ_W'(SIZE_Z - 1)) ? '0 : z + CZ_W'(1);
	assign zm = (z == '0) ? CZ_W'(SIZE_Z - 1) : z - CZ_W'(1);

	assign in_stall = (cq_cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));

	// unused request codes are taken and dropped
	always_comb begin
		push = 1'b0;
		kind = KIND_LOAD;
		if (in_valid && !in_stall) begin
			unique case (req_type)
				REQ_LOAD: begin
					push = 1'b1;
					kind = KIND_LOAD;
				end
				REQ_UPDATE: begin
					push = 1'b1;
					kind = KIND_UPDATE;
				end
				REQ_SWAP: begin
					push = 1'b1;
					kind = KIND_SWAP;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		entry.kind  = kind;
		entry.x     = x;
		entry.xp    = xp;
		entry.xm    = xm;
		entry.y     = y;
		entry.yp    = yp;
		entry.ym    = ym;
		entry.z     = z;
		entry.zp    = zp;
		entry.zm    = zm;
		entry.value = sample_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wr_q  <= '0;
			cq_rd_q  <= '0;
			cq_cnt_q <= '0;
		end else begin
			if (push) begin
				cq_wr_q <= cq_wr_q + CMDQ_PW'(1);
			end
			if (cmd_pop) begin
				cq_rd_q <= cq_rd_q + CMDQ_PW'(1);
			end
			case ({push, cmd_pop})
				2'b10:   cq_cnt_q <= cq_cnt_q + CMDQ_CNT_W'(1);
				2'b01:   cq_cnt_q <= cq_cnt_q - CMDQ_CNT_W'(1);
				default: cq_cnt_q <= cq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cq_mem_q[cq_wr_q] <= entry;
		end
	end

	assign cmd_valid = (cq_cnt_q != '0);
	assign cmd       = cq_mem_q[cq_rd_q];

endmodule
`default_nettype wire

@@ design/dif3d_calc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dif3d_calc: stencil arithmetic pipeline
// Differences, gain products, rounded sum, centre add and saturation.
// ----------------------------------------------------------------------------
module dif3d_calc import dif3d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  stencil_t                 st,
	input  logic [ADDR_W-1:0]        in_addr,
	input  logic [GAIN_W-1:0]        gain_x,
	input  logic [GAIN_W-1:0]        gain_y,
	input  logic [GAIN_W-1:0]        gain_z,
	output logic                     res_valid,
	output logic [ADDR_W-1:0]        res_addr,
	output logic signed [DATA_W-1:0] res_value
);

	localparam logic signed [52:0] ROUND_HALF = 53'sd32768;
	localparam logic signed [37:0] SAT_MAX    = 38'sd2147483647;
	localparam logic signed [37:0] SAT_MIN    = -38'sd2147483648;

	logic signed [33:0] c_e, xp_e, xm_e, yp_e, ym_e, zp_e, zm_e;
	logic signed [16:0] gx, gy, gz;
	logic signed [36:0] q;
	logic signed [37:0] nv;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [33:0]       dx_s1, dy_s1, dz_s1;
	logic signed [50:0]       px_s2, py_s2, pz_s2;
	logic signed [52:0]       acc_s3;
	logic signed [DATA_W-1:0] c_s1, c_s2, c_s3;
	logic [ADDR_W-1:0]        addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [DATA_W-1:0] value_s4;

	assign c_e  = 34'(st.c);
	assign xp_e = 34'(st.xp);
	assign xm_e = 34'(st.xm);
	assign yp_e = 34'(st.yp);
	assign ym_e = 34'(st.ym);
	assign zp_e = 34'(st.zp);
	assign zm_e = 34'(st.zm);

	assign gx = $signed({1'b0, gain_x});
	assign gy = $signed({1'b0, gain_y});
	assign gz = $signed({1'b0, gain_z});

	// floor of the rounded sum over 2^16, then add the centre
	assign q  = $signed(acc_s3[52:16]);
	assign nv = 38'(q) + 38'(c_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= xp_e + xm_e - (c_e <<< 1);
		dy_s1   <= yp_e + ym_e - (c_e <<< 1);
		dz_s1   <= zp_e + zm_e - (c_e <<< 1);
		c_s1    <= st.c;
		addr_s1 <= in_addr;

		px_s2   <= dx_s1 * gx;
		py_s2   <= dy_s1 * gy;
		pz_s2   <= dz_s1 * gz;
		c_s2    <= c_s1;
		addr_s2 <= addr_s1;

		acc_s3  <= 53'(px_s2) + 53'(py_s2) + 53'(pz_s2) + ROUND_HALF;
		c_s3    <= c_s2;
		addr_s3 <= addr_s2;

		if (nv > SAT_MAX) begin
			value_s4 <= SAT_MAX[31:0];
		end else if (nv < SAT_MIN) begin
			value_s4 <= SAT_MIN[31:0];
		end else begin
			value_s4 <= nv[31:0];
		end
		addr_s4 <= addr_s3;
	end

	assign res_valid = valid_s4;
	assign res_addr  = addr_s4;
	assign res_value = value_s4;

endmodule
`default_nettype wire

@@ design/dif3d_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dif3d_back: command execution
// Sequences grid reads, runs the arithmetic, writes back, queues results.
// ----------------------------------------------------------------------------
module dif3d_back import dif3d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  cmd_t                     cmd,
	output logic                     cmd_pop,
	input  logic [GAIN_W-1:0]        gain_x,
	input  logic [GAIN_W-1:0]        gain_y,
	input  logic [GAIN_W-1:0]        gain_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] new_value
);

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_THIRD,
		PH_LAST
	} phase_t;

	phase_t                   phase_q, phase_d, rd_phase_q;
	logic                     bank_q;
	logic                     rd_valid_q;
	logic [OQ_CNT_W-1:0]      pend_q;
	logic [OQ_CNT_W-1:0]      oq_cnt_q;
	logic [OQ_PW-1:0]         oq_wr_q;
	logic [OQ_PW-1:0]         oq_rd_q;
	logic signed [DATA_W-1:0] oq_mem_q [OUTQ_DEPTH];

	logic issue_upd, do_load, do_swap, do_drop, rd_en, oq_pop, room;

	cx_t ax, bx;
	cy_t ay, by;
	cz_t az, bz;
	pt_t pt_a, pt_b;

	logic [ADDR_W-1:0]        raddr_a, raddr_b, waddr, wb_addr_q, res_addr;
	logic [DATA_W-1:0]        rdata_a, rdata_b, wdata;
	logic                     we;
	logic signed [DATA_W-1:0] c_q, xp_q, xm_q, yp_q, ym_q, zp_q, res_value;
	logic                     res_valid, calc_valid;
	stencil_t                 st;

	// results in flight plus queued results never exceed the queue depth
	assign room = ((OQ_CNT_W + 1)'(pend_q) + (OQ_CNT_W + 1)'(oq_cnt_q))
	              < (OQ_CNT_W + 1)'(OUTQ_DEPTH);

	always_comb begin
		issue_upd = 1'b0;
		do_load   = 1'b0;
		do_swap   = 1'b0;
		do_drop   = 1'b0;
		if (cmd_valid && phase_q == PH_FIRST) begin
			unique case (cmd.kind)
				KIND_LOAD:   do_load   = (pend_q == '0);
				KIND_UPDATE: issue_upd = room;
				KIND_SWAP:   do_swap   = (pend_q == '0);
				default:     do_drop   = 1'b1;
			endcase
		end
	end

	assign rd_en   = issue_upd || (phase_q != PH_FIRST);
	assign cmd_pop = do_load || do_swap || do_drop || (phase_q == PH_LAST);

	always_comb begin
		unique case (phase_q)
			PH_FIRST:  phase_d = issue_upd ? PH_SECOND : PH_FIRST;
			PH_SECOND: phase_d = PH_THIRD;
			PH_THIRD:  phase_d = PH_LAST;
			PH_LAST:   phase_d = PH_FIRST;
		endcase
	end

	// two neighbor reads per cycle, centre first
	always_comb begin
		ax = cmd.x;
		ay = cmd.y;
		az = cmd.z;
		bx = cmd.x;
		by = cmd.y;
		bz = cmd.z;
		unique case (phase_q)
			PH_FIRST: begin
				bx = cmd.xp;
			end
			PH_SECOND: begin
				ax = cmd.xm;
				by = cmd.yp;
			end
			PH_THIRD: begin
				ay = cmd.ym;
				bz = cmd.zp;
			end
			PH_LAST: begin
				az = cmd.zm;
				bz = cmd.zm;
			end
		endcase
	end

	assign pt_a    = point_index(ax, ay, az);
	assign pt_b    = point_index(bx, by, bz);
	assign raddr_a = {bank_q, pt_a};
	assign raddr_b = {bank_q, pt_b};

	// a load only goes when no result is pending, so the write port is free
	assign we    = res_valid || do_load;
	assign waddr = res_valid ? res_addr : {bank_q, pt_a};
	assign wdata = res_valid ? res_value : cmd.value;

	dif3d_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RAM_DEPTH)
	) u_grid (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign calc_valid = rd_valid_q && (rd_phase_q == PH_LAST);

	always_comb begin
		st.c  = c_q;
		st.xp = xp_q;
		st.xm = xm_q;
		st.yp = yp_q;
		st.ym = ym_q;
		st.zp = zp_q;
		st.zm = $signed(rdata_a);
	end

	dif3d_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (calc_valid),
		.st        (st),
		.in_addr   (wb_addr_q),
		.gain_x    (gain_x),
		.gain_y    (gain_y),
		.gain_z    (gain_z),
		.res_valid (res_valid),
		.res_addr  (res_addr),
		.res_value (res_value)
	);

	assign out_valid = (oq_cnt_q != '0);
	assign new_value = oq_mem_q[oq_rd_q];
	assign oq_pop    = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			bank_q     <= 1'b0;
			rd_valid_q <= 1'b0;
			pend_q     <= '0;
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_cnt_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			rd_valid_q <= rd_en;
			if (do_swap) begin
				bank_q <= ~bank_q;
			end
			case ({issue_upd, res_valid})
				2'b10:   pend_q <= pend_q + OQ_CNT_W'(1);
				2'b01:   pend_q <= pend_q - OQ_CNT_W'(1);
				default: pend_q <= pend_q;
			endcase
			if (res_valid) begin
				oq_wr_q <= oq_wr_q + OQ_PW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_PW'(1);
			end
			case ({res_valid, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
				2'b01:   oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_phase_q <= phase_q;
		if (issue_upd) begin
			wb_addr_q <= {~bank_q, pt_a};
		end
		if (rd_valid_q) begin
			case (rd_phase_q)
				PH_FIRST: begin
					c_q  <= $signed(rdata_a);
					xp_q <= $signed(rdata_b);
				end
				PH_SECOND: begin
					xm_q <= $signed(rdata_a);
					yp_q <= $signed(rdata_b);
				end
				PH_THIRD: begin
					ym_q <= $signed(rdata_a);
					zp_q <= $signed(rdata_b);
				end
				default: begin
				end
			endcase
		end
		if (res_valid) begin
			oq_mem_q[oq_wr_q] <= res_value;
		end
	end

`ifndef NO_ASSERTIONS
	a_wr_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && do_load))
		else $error("load and write-back collide on the grid write port");

	a_bank_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != '0) |=> $stable(bank_q))
		else $error("bank flipped while an update was in flight");

	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (oq_cnt_q < OQ_CNT_W'(OUTQ_DEPTH)))
		else $error("result arrived with the output queue full");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_FIRST) |-> cmd_valid)
		else $error("update command left the queue before its reads finished");

	a_pend_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (pend_q != '0))
		else $error("result without a pending update");
`endif

endmodule
`default_nettype wire

@@ design/diffusion_stencil_3d_periodic_core.sv @@
`default_nettype none
// Path: an update goes through the command queue, its read phases, the arithmetic pipeline,
// then the grid write-back and the output queue.
// Reads: an update's seven grid reads share the RAM's two ports; the next update can start
// once they end; loads and swaps wait behind any update until its write-back.
// Reset: control state, output queue and bank select clear at once, gains go to 655;
// grid contents stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// diffusion_stencil_3d_periodic_core: seven-point 3D heat diffusion step
// Periodic grid in two ping-pong banks; load, update and swap requests.
// ----------------------------------------------------------------------------
module diffusion_stencil_3d_periodic_core import dif3d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic [POS_W-1:0]         x_pos,
	input  logic [POS_W-1:0]         y_pos,
	input  logic [POS_W-1:0]         z_pos,
	input  logic signed [DATA_W-1:0] sample_value,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] new_value,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data
);

	logic [GAIN_W-1:0] gain_x_q;
	logic [GAIN_W-1:0] gain_y_q;
	logic [GAIN_W-1:0] gain_z_q;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// Gain registers. The user must write them only while the core is idle; the block does
	// not enforce it, and the arithmetic pipeline reads them live. An index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q <= GAIN_RESET;
			gain_y_q <= GAIN_RESET;
			gain_z_q <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GAIN_X: gain_x_q <= cfg_data;
				CFG_GAIN_Y: gain_y_q <= cfg_data;
				CFG_GAIN_Z: gain_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: take each transfer, wrap the coordinates into the grid,
	// work out the six periodic neighbors and queue the classified command.
	// Unused request codes are taken and dropped here.
	dif3d_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.z_pos        (z_pos),
		.sample_value (sample_value),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	// Back end: execute commands in order. A load writes the active bank;
	// a swap flips the bank once no update is in flight; an update reads
	// the centre and neighbors in its read phases, runs the four-stage
	// arithmetic pipeline, writes the other bank and pushes the result into
	// the output queue. Updates only start when the queue has room reserved.
	dif3d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.gain_x    (gain_x_q),
		.gain_y    (gain_y_q),
		.gain_z    (gain_z_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_value (new_value)
	);

endmodule
`default_nettype wire

@@ bench/tb_diffusion_stencil_3d_periodic_core.sv @@
// ----------------------------------------------------------------------------
// tb_diffusion_stencil_3d_periodic_core: self-checking bench of the 3D stencil
// A directed table runs first, then bursts of random loads, updates and swaps.
// A shadow grid predicts each new_value the table does not give, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_diffusion_stencil_3d_periodic_core import dif3d_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// codes the package leaves unnamed
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// Q16.16 values used by the directed table
	localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN   = 32'h8000_0000;
	localparam longint            SAT_HI  = 64'sd2147483647;
	localparam longint            SAT_LO  = -64'sd2147483648;

	localparam int SETTLE_CYCLES   = 24;
	localparam int MAX_GAP         = 24;
	localparam int RANDOM_PER_SEG  = 265;
	localparam int CYCLE_LIMIT     = 600000;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	// one row of the directed table; a config row carries its index in code
	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        code;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
		logic [DATA_W-1:0] value;
		logic              typed;
		logic [DATA_W-1:0] typed_value;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               req_type;
	logic [POS_W-1:0]         x_pos;
	logic [POS_W-1:0]         y_pos;
	logic [POS_W-1:0]         z_pos;
	logic signed [DATA_W-1:0] sample_value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] new_value;
	logic                     cfg_wr_en;
	logic [1:0]               cfg_index;
	logic [GAIN_W-1:0]        cfg_data;

	// shadow of the block: both banks, which points hold data, bank select, gains
	logic [DATA_W-1:0] grid_banks [2*POINTS];
	bit                grid_written [2*POINTS];
	int                cur_bank = 0;
	int                gain_x_now = int'(GAIN_RESET);
	int                gain_y_now = int'(GAIN_RESET);
	int                gain_z_now = int'(GAIN_RESET);

	logic [DATA_W-1:0] pending_new_values [$];
	logic [DATA_W-1:0] oldest_value;
	stim_row_t         directed_rows [$];
	int                requests_sent = 0;
	int                error_count = 0;
	int                cycle_count = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;

	diffusion_stencil_3d_periodic_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.z_pos        (z_pos),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.new_value    (new_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// flat index of a point in the shadow grid, bank on top
	function automatic int grid_slot(int b, int x, int y, int z);
		return b * POINTS + (x * SIZE_Y + y) * SIZE_Z + z;
	endfunction

	function automatic bit is_known(int x, int y, int z);
		return grid_written[grid_slot(cur_bank, x, y, z)];
	endfunction

	// k = 0 centre, 1/2 x plus/minus, 3/4 y plus/minus, 5/6 z plus/minus, wrapped
	function automatic void stencil_point(input int x, y, z, k, output int px, py, pz);
		px = x;
		py = y;
		pz = z;
		case (k)
			1: px = (x + 1) % SIZE_X;
			2: px = (x + SIZE_X - 1) % SIZE_X;
			3: py = (y + 1) % SIZE_Y;
			4: py = (y + SIZE_Y - 1) % SIZE_Y;
			5: pz = (z + 1) % SIZE_Z;
			6: pz = (z + SIZE_Z - 1) % SIZE_Z;
			default: ;
		endcase
	endfunction

	// new value of one point: centre plus the gain-weighted second differences,
	// rounded half up at 2^-16 and saturated to 32 bits
	function automatic logic [DATA_W-1:0] diffuse_point(int x, int y, int z);
		longint pts [7];
		longint dx, dy, dz, acc, nv;
		int     px, py, pz;
		for (int k = 0; k < 7; k++) begin
			stencil_point(x, y, z, k, px, py, pz);
			pts[k] = $signed(grid_banks[grid_slot(cur_bank, px, py, pz)]);
		end
		dx = pts[1] + pts[2] - 2 * pts[0];
		dy = pts[3] + pts[4] - 2 * pts[0];
		dz = pts[5] + pts[6] - 2 * pts[0];
		acc = dx * gain_x_now + dy * gain_y_now + dz * gain_z_now;
		nv = pts[0] + ((acc + 32768) >>> 16);
		if (nv > SAT_HI) begin
			nv = SAT_HI;
		end
		if (nv < SAT_LO) begin
			nv = SAT_LO;
		end
		return nv[DATA_W-1:0];
	endfunction

	// advance the shadow on one accepted request; an update queues its new value
	task automatic apply_request(input logic [1:0] code, input logic [POS_W-1:0] xq, yq, zq,
			input logic [DATA_W-1:0] value, input logic typed,
			input logic [DATA_W-1:0] typed_value);
		int                x, y, z;
		logic [DATA_W-1:0] fresh;
		x = int'(xq) % SIZE_X;
		y = int'(yq) % SIZE_Y;
		z = int'(zq) % SIZE_Z;
		case (code)
			REQ_LOAD: begin
				grid_banks[grid_slot(cur_bank, x, y, z)] = value;
				grid_written[grid_slot(cur_bank, x, y, z)] = 1'b1;
			end
			REQ_UPDATE: begin
				fresh = diffuse_point(x, y, z);
				grid_banks[grid_slot(1 - cur_bank, x, y, z)] = fresh;
				grid_written[grid_slot(1 - cur_bank, x, y, z)] = 1'b1;
				pending_new_values.push_back(typed ? typed_value : fresh);
			end
			REQ_SWAP: begin
				cur_bank = 1 - cur_bank;
			end
			default: ;   // unused code: no state change, no result
		endcase
	endtask

	// present one request after a random gap and hold it until the transfer
	task automatic send_req(input logic [1:0] code, input logic [POS_W-1:0] x, y, z,
			input logic [DATA_W-1:0] value, input logic typed,
			input logic [DATA_W-1:0] typed_value);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= code;
		x_pos        <= x;
		y_pos        <= y;
		z_pos        <= z;
		sample_value <= value;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		apply_request(code, x, y, z, value, typed, typed_value);
		if (code != REQ_UNUSED) begin
			requests_sent++;
		end
	endtask

	// write one gain once the block has gone quiet: drain results, then wait out
	// any load or swap still in flight
	task automatic write_cfg(input logic [1:0] idx, input logic [GAIN_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_new_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_GAIN_X: gain_x_now = int'(data);
			CFG_GAIN_Y: gain_y_now = int'(data);
			CFG_GAIN_Z: gain_z_now = int'(data);
			default: ;   // out-of-range index: dropped
		endcase
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_gains(input logic [GAIN_W-1:0] gx, gy, gz);
		write_cfg(CFG_GAIN_X, gx);
		write_cfg(CFG_GAIN_Y, gy);
		write_cfg(CFG_GAIN_Z, gz);
	endtask

	task automatic add_row(input row_kind_t kind, input logic [1:0] code,
			input int x, y, z, input logic [DATA_W-1:0] value,
			input logic typed, input logic [DATA_W-1:0] typed_value);
		directed_rows.push_back('{kind, code, POS_W'(x), POS_W'(y), POS_W'(z), value,
			typed, typed_value});
	endtask

	// favor the faces of the grid so the periodic wrap gets plenty of traffic
	function automatic int pick_coord(int size);
		if ($urandom_range(1) == 0) begin
			case ($urandom_range(3))
				0: return 0;
				1: return 1;
				2: return size - 2;
				default: return size - 1;
			endcase
		end
		return $urandom_range(size - 1);
	endfunction

	function automatic logic [DATA_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return $urandom();
		endcase
	endfunction

	// one well-formed burst: fill a stencil, update its centre, maybe a neighbor,
	// then now and then a swap or an unused code
	task automatic stencil_burst();
		int fx, fy, fz, px, py, pz, cx, cy, cz, kk, n_upd;
		bit ready;
		fx = pick_coord(SIZE_X);
		fy = pick_coord(SIZE_Y);
		fz = pick_coord(SIZE_Z);
		for (int k = 0; k < 7; k++) begin
			stencil_point(fx, fy, fz, k, px, py, pz);
			if (!is_known(px, py, pz) || $urandom_range(2) == 0) begin
				send_req(REQ_LOAD, POS_W'(px), POS_W'(py), POS_W'(pz), rand_sample(),
					1'b0, '0);
			end
		end
		// zero updates leaves a broken burst: loads with nothing to show for them
		n_upd = $urandom_range(1, 2);
		repeat (n_upd) send_req(REQ_UPDATE, POS_W'(fx), POS_W'(fy), POS_W'(fz), $urandom(),
			1'b0, '0);
		kk = $urandom_range(1, 6);
		stencil_point(fx, fy, fz, kk, cx, cy, cz);
		ready = 1'b1;
		for (int k = 0; k < 7; k++) begin
			stencil_point(cx, cy, cz, k, px, py, pz);
			ready &= is_known(px, py, pz);
		end
		if (ready && $urandom_range(2) == 0) begin
			send_req(REQ_UPDATE, POS_W'(cx), POS_W'(cy), POS_W'(cz), $urandom(), 1'b0, '0);
		end
		if ($urandom_range(4) == 0) begin
			send_req(REQ_SWAP, POS_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()),
				$urandom(), 1'b0, '0);
		end
		if ($urandom_range(9) == 0) begin
			send_req(REQ_UNUSED, POS_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()),
				$urandom(), 1'b0, '0);
		end
	endtask

	// receiver side: stall at the rate of the current idling phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// compare every result transfer with the oldest predicted value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_new_values.size() == 0) begin
				$error("new_value: no update pending, actual %h", new_value);
				error_count++;
			end else begin
				oldest_value = pending_new_values.pop_front();
				if (new_value !== oldest_value) begin
					$error("new_value: expected %h, actual %h", oldest_value, new_value);
					error_count++;
				end
			end
		end
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("diffusion_stencil_3d_periodic_core regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		req_type     <= REQ_LOAD;
		x_pos        <= '0;
		y_pos        <= '0;
		z_pos        <= '0;
		sample_value <= '0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= CFG_GAIN_X;
		cfg_data     <= '0;

		// Directed table. Stencil of the origin at 1.0: every difference is zero,
		// and the minus neighbors wrap to the far faces.
		add_row(ROW_REQ, REQ_LOAD, 0, 0, 0, ONE_Q16, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 1, 0, 0, ONE_Q16, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 15, 0, 0, ONE_Q16, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 1, 0, ONE_Q16, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 15, 0, ONE_Q16, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 0, 1, ONE_Q16, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 0, 15, ONE_Q16, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b1, ONE_Q16);
		// a write to the unused register index must leave the reset gains alone:
		// centre 0 under 1.0 neighbors gives 6 * 655 ulp
		add_row(ROW_CFG, CFG_UNUSED, 0, 0, 0, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 0, 0, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b1, 32'h0000_0F5A);
		// full gains: extreme centres saturate in both directions
		add_row(ROW_CFG, CFG_GAIN_X, 0, 0, 0, 32'h0000_FFFF, 1'b0, '0);
		add_row(ROW_CFG, CFG_GAIN_Y, 0, 0, 0, 32'h0000_FFFF, 1'b0, '0);
		add_row(ROW_CFG, CFG_GAIN_Z, 0, 0, 0, 32'h0000_FFFF, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 0, 0, Q_MIN, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b1, Q_MAX);
		add_row(ROW_REQ, REQ_LOAD, 0, 0, 0, Q_MAX, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b1, Q_MIN);
		// zero gains: the centre passes through unchanged
		add_row(ROW_CFG, CFG_GAIN_X, 0, 0, 0, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_CFG, CFG_GAIN_Y, 0, 0, 0, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_CFG, CFG_GAIN_Z, 0, 0, 0, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b1, Q_MAX);
		// the unused request code must not act as a load
		add_row(ROW_REQ, REQ_UNUSED, 0, 0, 0, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b1, Q_MAX);
		// two swaps bring the first bank back
		add_row(ROW_REQ, REQ_SWAP, 15, 15, 15, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(ROW_REQ, REQ_SWAP, 0, 0, 0, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b1, Q_MAX);
		// uneven gains with rounding: left to the predictor
		add_row(ROW_CFG, CFG_GAIN_X, 0, 0, 0, 32'h0000_0001, 1'b0, '0);
		add_row(ROW_CFG, CFG_GAIN_Y, 0, 0, 0, 32'h0000_8000, 1'b0, '0);
		add_row(ROW_CFG, CFG_GAIN_Z, 0, 0, 0, 32'h0000_FFFF, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 15, 0, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(ROW_REQ, REQ_LOAD, 0, 0, 15, 32'h7FFF_0000, 1'b0, '0);
		add_row(ROW_REQ, REQ_UPDATE, 0, 0, 0, '0, 1'b0, '0);

		send_idle_pct = 35;
		recv_idle_pct = 77;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_cfg(directed_rows[i].code, directed_rows[i].value[GAIN_W-1:0]);
			end else begin
				send_req(directed_rows[i].code, directed_rows[i].x, directed_rows[i].y,
					directed_rows[i].z, directed_rows[i].value, directed_rows[i].typed,
					directed_rows[i].typed_value);
			end
		end

		// Random part: six segments, each with its own gains; idling flips from a
		// slow receiver to a slow sender, then stops altogether.
		for (int seg = 0; seg < 6; seg++) begin
			send_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 77 : 0;
			recv_idle_pct = (seg < 2) ? 77 : (seg < 4) ? 35 : 0;
			case (seg)
				1: write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: write_gains(16'h0000, 16'h0000, 16'h0000);
				4: write_gains(16'h0001, 16'hFFFF, 16'h0000);
				5: write_gains(GAIN_W'($urandom_range(4000)), GAIN_W'($urandom_range(4000)),
					GAIN_W'($urandom_range(4000)));
				default: write_gains(GAIN_W'($urandom_range(65535)),
					GAIN_W'($urandom_range(65535)), GAIN_W'($urandom_range(65535)));
			endcase
			while (requests_sent < (seg + 1) * RANDOM_PER_SEG + directed_rows.size()) begin
				stencil_burst();
			end
		end

		// drain: every predicted value must come back, then let the pipe go quiet
		in_valid <= 1'b0;
		while (pending_new_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("diffusion_stencil_3d_periodic_core regression: pass");
		end else begin
			$display("diffusion_stencil_3d_periodic_core regression: fail");
		end
		$finish;
	end

endmodule
